// ===== rtl/core/isort_pkg.sv =====
// Package for the insertion sorter: sizes, transaction types, control structs.
`default_nettype none
package isort_pkg;

  // Capacity of the sorted store
  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  // Input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_batch;
    logic                     dropped;
  } out_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_in;    // capture input, pos <= count
    logic set_ovf;    // store full, flag the batch
    logic wr_shift;   // move read entry up to pos
    logic ptr_dec;    // pos <= pos - 1
    logic wr_new;     // write new value at pos, count++
    logic emit_rd;    // read entry idx
    logic emit_out;   // load result register, idx++
    logic batch_clr;  // count, overflow and idx back to zero
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic pos_one;
    logic greater;
    logic last_item;
    logic idx_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/isort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module isort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/isort_dp.sv =====
// Datapath of the insertion sorter: store, count, pointers, result register.
`default_nettype none
module isort_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire isort_pkg::in_t  in_i,
  input  wire isort_pkg::cmd_t cmd_i,
  output isort_pkg::sts_t      sts_o,
  output isort_pkg::out_t      result_o,
  output logic                 result_valid_o
);
  import isort_pkg::*;

  in_t               in_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  out_t              out_q;
  logic              out_valid_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              idx_last;

  isort_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Store port steering
  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_new;
  assign ram_wdata = cmd_i.wr_new ? in_q.value : ram_rdata;
  assign ram_raddr = cmd_i.emit_rd ? idx_q : (pos_q - ADDR_W'(1));

  assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  // Status to controller
  assign sts_o.full      = (cnt_q == CNT_W'(MAX_ITEMS));
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.pos_one   = (pos_q == ADDR_W'(1));
  assign sts_o.greater   = ($signed(ram_rdata) > in_q.value);
  assign sts_o.last_item = in_q.last_item;
  assign sts_o.idx_last  = idx_last;

  // Next-state of counters and pointers
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    pos_d = pos_q;
    idx_d = idx_q;
    if (cmd_i.load_in) pos_d = cnt_q[ADDR_W-1:0];
    if (cmd_i.ptr_dec) pos_d = pos_q - ADDR_W'(1);
    if (cmd_i.set_ovf) ovf_d = 1'b1;
    if (cmd_i.wr_new)  cnt_d = cnt_q + CNT_W'(1);
    if (cmd_i.emit_out) idx_d = idx_q + ADDR_W'(1);
    if (cmd_i.batch_clr) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      idx_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= cmd_i.emit_out;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load_in) in_q <= in_i;
    if (cmd_i.emit_out) begin
      out_q.sorted_value <= $signed(ram_rdata);
      out_q.end_of_batch <= idx_last;
      out_q.dropped      <= ovf_q;
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/isort_ctrl.sv =====
// Controller of the insertion sorter: sequences insert and emit steps.
`default_nettype none
module isort_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire isort_pkg::sts_t sts_i,
  output isort_pkg::cmd_t      cmd_o
);
  import isort_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = sts_i.last_item ? ST_EMIT_RD : ST_IDLE;
        end else if (sts_i.pos_zero) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        // datapath reads entry pos-1 by default
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // entry above the new value moves up one place
        if (sts_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          state_d        = sts_i.pos_one ? ST_PLACE : ST_RD;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.wr_new = 1'b1;
        state_d      = sts_i.last_item ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd_o.emit_out = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.batch_clr = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/insertion_sorter_top.sv =====
// Top level of the insertion sorter: controller plus datapath.
//
//   channel   signals                    direction  transfer
//   input     start, busy, in_i          in         start & !busy at clk edge
//   result    result_valid_o, result_o   out        one-cycle strobe, no stall
//
// An input transaction is checked first, then each held entry that is compared
// is read and then compared, one at a time, before the new value is placed; this
// is set by the single read port of the store and its registered read.
// A last item then emits the held entries, never back to back, same reason.
// Reset clears the count, overflow flag and controller; the store is not cleared.
// The receiver cannot stall; busy holds off new input transactions.
`default_nettype none
module insertion_sorter_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire isort_pkg::in_t in_i,
  output isort_pkg::out_t     result_o,
  output logic                result_valid_o
);
  import isort_pkg::*;

  cmd_t cmd;
  sts_t sts;

  isort_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  isort_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/isort_checker.sv =====
// Port-level assertions for the insertion sorter and their bind.
`default_nettype none
module isort_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire isort_pkg::out_t result_o,
  input wire logic            result_valid_o
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // No result in the cycle after an accepted transaction
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result right after accepted transaction");

  // Results are never back to back
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results in consecutive cycles");

  // More results pending keeps the block busy
  a_batch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.end_of_batch |-> busy)
    else $error("idle in the middle of a batch");

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_o      (result_o),
  .result_valid_o(result_valid_o)
);
`default_nettype wire

// ===== verif/insertion_sorter_checker.sv =====
// Checker for the insertion sorter: watches both channels, predicts sorted batches, compares.
`timescale 1ns / 100ps
module insertion_sorter_checker
  import isort_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  in_t  in_i,
  input  out_t result_o,
  input  logic result_valid_o,
  output int   fail_count_o,
  output int   pending_o,
  output int   batches_o,
  output int   drop_batches_o,
  output int   results_o
);

  // Predicted batch contents, kept ascending and stable
  logic signed [DATA_W-1:0] sort_store[$];
  logic                     batch_overflow = 1'b0;
  out_t                     expected_results[$];

  int fail_count   = 0;
  int pending      = 0;
  int batches      = 0;
  int drop_batches = 0;
  int results_seen = 0;

  assign fail_count_o   = fail_count;
  assign pending_o      = pending;
  assign batches_o      = batches;
  assign drop_batches_o = drop_batches;
  assign results_o      = results_seen;

  // Insert one value; on the last item, queue the whole batch in order
  task automatic predict_batch(input in_t txn);
    logic signed [DATA_W-1:0] v;
    int                       pos;
    int                       n;
    out_t                     exp_r;
    v = txn.value;
    if (sort_store.size() >= MAX_ITEMS) begin
      batch_overflow = 1'b1;
    end else begin
      pos = sort_store.size();
      // equal entries stay below the new value
      while (pos > 0 && sort_store[pos-1] > v) pos--;
      sort_store.insert(pos, v);
    end
    if (txn.last_item) begin
      n = sort_store.size();
      for (int k = 0; k < n; k++) begin
        exp_r.sorted_value = sort_store[k];
        exp_r.end_of_batch = (k == n - 1);
        exp_r.dropped      = batch_overflow;
        expected_results.push_back(exp_r);
      end
      batches++;
      if (batch_overflow) drop_batches++;
      sort_store.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result(input out_t act);
    out_t exp_r;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("unexpected result: sorted_value %0d end_of_batch %0b dropped %0b",
             act.sorted_value, act.end_of_batch, act.dropped);
      fail_count++;
    end else begin
      exp_r = expected_results.pop_front();
      if (act.sorted_value !== exp_r.sorted_value) begin
        $error("sorted_value mismatch: expected %0d, actual %0d",
               exp_r.sorted_value, act.sorted_value);
        fail_count++;
      end
      if (act.end_of_batch !== exp_r.end_of_batch) begin
        $error("end_of_batch mismatch: expected %0b, actual %0b",
               exp_r.end_of_batch, act.end_of_batch);
        fail_count++;
      end
      if (act.dropped !== exp_r.dropped) begin
        $error("dropped mismatch: expected %0b, actual %0b", exp_r.dropped, act.dropped);
        fail_count++;
      end
    end
  endtask

  // Results belong to earlier batches, so check them before predicting
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) check_result(result_o);
      if (start && !busy) predict_batch(in_i);
      pending = expected_results.size();
    end
  end

endmodule

// ===== verif/insertion_sorter_top_tb.sv =====
// Testbench top for the insertion sorter: clock, reset, batch stimulus and verdict.
`timescale 1ns / 100ps
module insertion_sorter_top_tb;
  import isort_pkg::*;

  localparam int RANDOM_ITEMS   = 220;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;

  logic clk_i          = 1'b0;
  logic rst_ni         = 1'b0;
  logic start          = 1'b0;
  in_t  in_i           = '0;
  logic busy;
  out_t result_o;
  logic result_valid_o;

  int fail_count;
  int pending;
  int batches;
  int drop_batches;
  int results_seen;
  int items_sent = 0;
  int quiet_cycles = 0;

  insertion_sorter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  insertion_sorter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .batches_o      (batches),
    .drop_batches_o (drop_batches),
    .results_o      (results_seen)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pending);
        $display("insertion_sorter_top_tb failed");
        $finish;
      end
    end
  end

  // Mostly random values, with small ranges for duplicates and the extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = 32'($urandom_range(0, 7)) - 32'sd4;
      7:          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:          v = 32'sh7FFF_FFFF - 32'($urandom_range(0, 3));
      default:    v = 32'sh8000_0000 + 32'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Idle gap of length n: drop start, with garbage on the input bus
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i  <= {$urandom, 1'($urandom_range(0, 1))};
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Present one transaction and hold it until the block takes it
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= {v, last};
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    items_sent++;
  endtask

  // One batch from a list of values; the final one carries last_item
  task automatic send_batch(input logic signed [DATA_W-1:0] vals[$], input bit burst);
    for (int i = 0; i < vals.size(); i++) begin
      send_item(vals[i], i == vals.size() - 1);
      if (!burst) idle_for(pick_gap());
    end
  endtask

  // Random batch of the given size
  task automatic send_random_batch(input int size, input bit burst);
    logic signed [DATA_W-1:0] vals[$];
    for (int i = 0; i < size; i++) vals.push_back(pick_value());
    send_batch(vals, burst);
  endtask

  initial begin
    logic signed [DATA_W-1:0] vals[$];
    int                       batch_idx;
    int                       size;
    int                       r;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-item batch at the minimum
    vals = '{32'sh8000_0000};
    send_batch(vals, 1'b1);
    // Extremes, zero and neighbors, last value equal to an earlier one
    vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd0};
    send_batch(vals, 1'b0);
    // Duplicates keep their arrival order
    vals = '{32'sd5, 32'sd5, -32'sd5, 32'sd5};
    send_batch(vals, 1'b1);
    // Descending input, every insert shifts the whole store
    vals = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
    send_batch(vals, 1'b0);
    // Maximum as the last item
    vals = '{-32'sd7, 32'sh7FFF_FFFF};
    send_batch(vals, 1'b1);

    // Random batches: mostly small, one filling the store exactly,
    // one overflowing it so the last item itself is dropped
    batch_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (batch_idx == 3) begin
        size = MAX_ITEMS;
      end else if (batch_idx == 8) begin
        size = MAX_ITEMS + 1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6)      size = $urandom_range(1, 4);
        else if (r < 9) size = $urandom_range(5, 12);
        else            size = $urandom_range(13, 24);
      end
      send_random_batch(size, $urandom_range(0, 3) == 0);
      idle_for(pick_gap());
      batch_idx++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d values in %0d batches, %0d batches overflowed the store",
             items_sent, batches, drop_batches);
    $display("checked %0d sorted results, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("insertion_sorter_top_tb passed");
    end else begin
      $display("insertion_sorter_top_tb failed");
    end
    $finish;
  end

endmodule
